// ----- hdl/pwass_pkg.sv -----
// Shared types and constants for the per-weight adaptive step scaler.
// No dependencies; used by the store, the arithmetic units and the top level.
package pwass_pkg;

   localparam int NUM_WEIGHTS = 256;
   localparam int IDX_W       = 8;
   localparam int CNT_W       = 9;
   localparam int DATA_W      = 32;

   // divider: Q16.16 numerator shifted up by 16, denominator up to 33 bits
   localparam int DIV_NUM_W   = 48;
   localparam int DIV_DEN_W   = 33;
   localparam int DIV_CNT_W   = 6;

   // square root of a 48-bit radicand
   localparam int SQRT_IN_W   = 48;
   localparam int SQRT_OUT_W  = 24;
   localparam int SQRT_CNT_W  = 5;

   // reset contents of the stores and reset register values
   localparam logic [DATA_W-1:0] VAR_RESET   = 32'd65536;
   localparam logic [DATA_W-1:0] SCALE_RESET = 32'd65470;
   localparam logic [DATA_W-1:0] LR_RESET    = 32'd65536;
   localparam logic [15:0]       BETA_RESET  = 16'd6554;
   localparam logic [DATA_W-1:0] EPS_RESET   = 32'd66;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 9'd256;
   localparam logic [DATA_W-1:0] SAT_MAX     = 32'hFFFF_FFFF;

   // configuration register indexes
   localparam logic [1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [1:0] CSR_DECAY_BETA    = 2'd1;
   localparam logic [1:0] CSR_EPSILON       = 2'd2;
   localparam logic [1:0] CSR_ACTIVE_COUNT  = 2'd3;

   // opcodes
   localparam logic OP_BEGIN_BATCH = 1'b0;
   localparam logic OP_GRADIENT    = 1'b1;

   // access to the variance and scale stores
   typedef struct packed {
      logic              rd_en;
      logic              wr_var;
      logic              wr_scl;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] var_data;
      logic [DATA_W-1:0] scl_data;
   } store_req_type;

endpackage

// ----- hdl/pwass_store.sv -----
// Variance and scale stores: two 256-entry synchronous memories with a registered read.
// A clearing pass after reset loads the reset contents. Depends on pwass_pkg.
module pwass_store (
   input  logic                           clock,
   input  logic                           reset,
   input  pwass_pkg::store_req_type       req,
   output logic                           ready,
   output logic [pwass_pkg::DATA_W-1:0]   var_q,
   output logic [pwass_pkg::DATA_W-1:0]   scl_q
);

   logic [pwass_pkg::DATA_W-1:0] var_mem [pwass_pkg::NUM_WEIGHTS];
   logic [pwass_pkg::DATA_W-1:0] scl_mem [pwass_pkg::NUM_WEIGHTS];
   logic [pwass_pkg::CNT_W-1:0]  clr_ff;
   logic                         clr_busy;
   logic [pwass_pkg::DATA_W-1:0] var_rd_ff;
   logic [pwass_pkg::DATA_W-1:0] scl_rd_ff;

   // top bit of the clear counter marks the end of the pass
   assign clr_busy = !clr_ff[pwass_pkg::CNT_W-1];

   // advance the clearing pass once per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clr_busy) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // write and read the memories
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         var_mem[clr_ff[pwass_pkg::IDX_W-1:0]] <= pwass_pkg::VAR_RESET;
         scl_mem[clr_ff[pwass_pkg::IDX_W-1:0]] <= pwass_pkg::SCALE_RESET;
      end else begin
         if (req.wr_var) begin
            var_mem[req.addr] <= req.var_data;
         end
         if (req.wr_scl) begin
            scl_mem[req.addr] <= req.scl_data;
         end
      end
      if (req.rd_en) begin
         var_rd_ff <= var_mem[req.addr];
         scl_rd_ff <= scl_mem[req.addr];
      end
   end

   assign ready = !clr_busy;
   assign var_q = var_rd_ff;
   assign scl_q = scl_rd_ff;

endmodule

// ----- hdl/pwass_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pwass_pkg for widths.
module pwass_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [pwass_pkg::DIV_NUM_W-1:0]     num,
   input  logic [pwass_pkg::DIV_DEN_W-1:0]     den,
   output logic                                done,
   output logic [pwass_pkg::DIV_NUM_W-1:0]     quo
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [pwass_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [pwass_pkg::DIV_NUM_W-1:0]   quo_ff;
   logic [pwass_pkg::DIV_DEN_W:0]     rem_ff;
   logic [pwass_pkg::DIV_DEN_W-1:0]   den_ff;
   logic [pwass_pkg::DIV_DEN_W:0]     shift;
   logic [pwass_pkg::DIV_DEN_W:0]     diff;
   logic                              fits;

   // one trial subtraction
   always_comb begin
      shift = {rem_ff[pwass_pkg::DIV_DEN_W-1:0], quo_ff[pwass_pkg::DIV_NUM_W-1]};
      diff  = shift - {1'b0, den_ff};
      fits  = shift >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == pwass_pkg::DIV_CNT_W'(pwass_pkg::DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift quotient in, keep partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff : shift;
         quo_ff <= {quo_ff[pwass_pkg::DIV_NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- hdl/pwass_sqrt.sv -----
// Bitwise integer square root, two radicand bits per cycle.
// Depends on pwass_pkg for widths.
module pwass_sqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [pwass_pkg::SQRT_IN_W-1:0]      radicand,
   output logic                                 done,
   output logic [pwass_pkg::SQRT_OUT_W-1:0]     root
);

   logic                               busy_ff;
   logic                               done_ff;
   logic [pwass_pkg::SQRT_CNT_W-1:0]   cnt_ff;
   logic [pwass_pkg::SQRT_IN_W-1:0]    x_ff;
   logic [pwass_pkg::SQRT_OUT_W-1:0]   root_ff;
   logic [pwass_pkg::SQRT_OUT_W+1:0]   rem_ff;
   logic [pwass_pkg::SQRT_OUT_W+1:0]   shift;
   logic [pwass_pkg::SQRT_OUT_W+1:0]   trial;
   logic                               fits;

   // trial subtraction of 4*root + 1
   always_comb begin
      shift = {rem_ff[pwass_pkg::SQRT_OUT_W-1:0],
               x_ff[pwass_pkg::SQRT_IN_W-1:pwass_pkg::SQRT_IN_W-2]};
      trial = {root_ff, 2'b01};
      fits  = shift >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == pwass_pkg::SQRT_CNT_W'(pwass_pkg::SQRT_OUT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // advance one root bit
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[pwass_pkg::SQRT_IN_W-3:0], 2'b00};
         rem_ff  <= fits ? shift - trial : shift;
         root_ff <= {root_ff[pwass_pkg::SQRT_OUT_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- hdl/per_weight_adaptive_step_scaler_core.sv -----
// Per-weight adaptive step scaler (vario-eta), top level.
// Depends on pwass_pkg, pwass_store, pwass_div and pwass_sqrt.
//
//  - req_ channel carries one beat per item: opcode, weight index, gradient.
//    Opcode begin-batch walks min(active_count, 256) weights, setting each
//    scale to rate / (sqrt(v) + eps) and decaying v; it returns no beat.
//    Opcode gradient updates the weight's variance and returns one rsp_ beat
//    with the gradient times the scale from the last batch start.
//  - csr_ port writes the four registers on any cycle with csr_write_enable;
//    write only while the block is idle.
//  - One item at a time: req_stall is high while an item is in work.
//  - Gradient path: ST_G_RD, ST_G_CHK, ST_G_DIV (the serial divider for the ratio),
//    ST_G_SQ, ST_G_ADD, ST_G_WR and ST_G_OUT; an overflowing ratio skips ST_G_SQ and
//    ST_G_ADD, and a zero rate or gradient skips the divider as well.
//  - Begin-batch: per weight walked, one store read, the serial square root, the
//    serial divider (skipped when the denominator is zero) and one store write.
//  - The result sits in an output register; a stalled rsp_ beat holds and the
//    next item may be accepted; a finished result waits only if the
//    register is still full.
//  - Reset restores the register defaults and starts a clearing pass that loads
//    both stores with their reset contents; req_stall stays high until it ends.
module per_weight_adaptive_step_scaler_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [pwass_pkg::IDX_W-1:0]     req_weight_index,
   input  logic signed [31:0]              req_gradient_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pwass_pkg::IDX_W-1:0]     rsp_out_index,
   output logic signed [31:0]              rsp_scaled_update,
   output logic                            rsp_saturated,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [31:0]                     csr_write_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_G_RD  = 4'd1;
   localparam logic [3:0] ST_G_CHK = 4'd2;
   localparam logic [3:0] ST_G_DIV = 4'd3;
   localparam logic [3:0] ST_G_SQ  = 4'd4;
   localparam logic [3:0] ST_G_ADD = 4'd5;
   localparam logic [3:0] ST_G_WR  = 4'd6;
   localparam logic [3:0] ST_G_OUT = 4'd7;
   localparam logic [3:0] ST_B_RD  = 4'd8;
   localparam logic [3:0] ST_B_SQ  = 4'd9;
   localparam logic [3:0] ST_B_SQW = 4'd10;
   localparam logic [3:0] ST_B_DIV = 4'd11;
   localparam logic [3:0] ST_B_DEC = 4'd12;

   // configuration registers
   logic [31:0]                  lr_ff;
   logic [15:0]                  beta_ff;
   logic [31:0]                  eps_ff;
   logic [pwass_pkg::CNT_W-1:0]  count_ff;

   // control
   logic [3:0]                   state_ff, state_in;
   logic [pwass_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pwass_pkg::CNT_W-1:0]  walk_ff, walk_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // item payload and working values
   logic [pwass_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [31:0]                  mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic                         sat_ff, sat_in;
   logic [31:0]                  v_ff, v_in;
   logic [31:0]                  s_ff, s_in;
   logic [31:0]                  vnew_ff, vnew_in;
   logic                         vwr_ff, vwr_in;
   logic [31:0]                  snew_ff, snew_in;
   logic [63:0]                  sq_ff, sq_in;
   logic [47:0]                  add_ff, add_in;
   logic [63:0]                  prod_ff, prod_in;
   logic [pwass_pkg::IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [31:0]                  rsp_upd_ff, rsp_upd_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   // unit connections
   pwass_pkg::store_req_type     st_req;
   logic                         st_ready;
   logic [31:0]                  st_var_q;
   logic [31:0]                  st_scl_q;
   logic                         div_start;
   logic [pwass_pkg::DIV_NUM_W-1:0] div_num;
   logic [pwass_pkg::DIV_DEN_W-1:0] div_den;
   logic                         div_done;
   logic [pwass_pkg::DIV_NUM_W-1:0] div_quo;
   logic                         sqrt_start;
   logic                         sqrt_done;
   logic [pwass_pkg::SQRT_OUT_W-1:0] sqrt_root;

   // combinational helpers
   logic                         req_beat;
   logic                         out_free;
   logic [31:0]                  grad_raw;
   logic [63:0]                  beta_prod;
   logic [48:0]                  var_sum;
   logic [48:0]                  decay_prod;
   logic [16:0]                  decay_factor;
   logic [32:0]                  denom;
   logic [47:0]                  prod_hi;

   pwass_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .ready (st_ready),
      .var_q (st_var_q),
      .scl_q (st_scl_q)
   );

   pwass_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   pwass_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({st_var_q, 16'd0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_stall = (state_ff != ST_IDLE) || !st_ready;
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign grad_raw  = req_gradient_value;

   // datapath arithmetic
   always_comb begin
      beta_prod    = 64'(sq_ff[63:16]) * 64'(beta_ff);
      var_sum      = {17'd0, v_ff} + {1'b0, add_ff};
      decay_factor = 17'h1_0000 - {1'b0, beta_ff};
      decay_prod   = 49'(v_ff) * 49'(decay_factor);
      denom        = {9'd0, sqrt_root} + {1'b0, eps_ff};
      prod_hi      = prod_ff[63:16];
   end

   // sequencer and next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      idx_in       = idx_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      v_in         = v_ff;
      s_in         = s_ff;
      vnew_in      = vnew_ff;
      vwr_in       = vwr_ff;
      snew_in      = snew_ff;
      sq_in        = sq_ff;
      add_in       = add_ff;
      prod_in      = prod_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_sat_in   = rsp_sat_ff;

      st_req       = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      sqrt_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               idx_in = req_weight_index;
               neg_in = grad_raw[31];
               mag_in = grad_raw[31] ? (~grad_raw + 32'd1) : grad_raw;
               sat_in = 1'b0;
               cnt_in = '0;
               if (req_opcode == pwass_pkg::OP_GRADIENT) begin
                  state_in = ST_G_RD;
               end else begin
                  walk_in = (count_ff > pwass_pkg::CNT_W'(pwass_pkg::NUM_WEIGHTS)) ?
                            pwass_pkg::CNT_W'(pwass_pkg::NUM_WEIGHTS) : count_ff;
                  state_in = (count_ff == '0) ? ST_IDLE : ST_B_RD;
               end
            end
         end

         // gradient: fetch the entry
         ST_G_RD: begin
            st_req.rd_en = 1'b1;
            st_req.addr  = idx_ff;
            state_in     = ST_G_CHK;
         end

         ST_G_CHK: begin
            v_in = st_var_q;
            s_in = st_scl_q;
            if (mag_ff == '0) begin
               vwr_in   = 1'b0;
               state_in = ST_G_WR;
            end else if (lr_ff == '0) begin
               vwr_in   = 1'b1;
               vnew_in  = pwass_pkg::SAT_MAX;
               sat_in   = 1'b1;
               state_in = ST_G_WR;
            end else begin
               div_start = 1'b1;
               div_num   = {mag_ff, 16'd0};
               div_den   = {1'b0, lr_ff};
               state_in  = ST_G_DIV;
            end
         end

         ST_G_DIV: begin
            if (div_done) begin
               if (div_quo[47:32] != '0) begin
                  vwr_in   = 1'b1;
                  vnew_in  = pwass_pkg::SAT_MAX;
                  sat_in   = 1'b1;
                  state_in = ST_G_WR;
               end else begin
                  sq_in    = 64'(div_quo[31:0]) * 64'(div_quo[31:0]);
                  state_in = ST_G_SQ;
               end
            end
         end

         ST_G_SQ: begin
            add_in   = beta_prod[63:16];
            state_in = ST_G_ADD;
         end

         // accumulate with saturation
         ST_G_ADD: begin
            vwr_in = 1'b1;
            if (var_sum[48:32] != '0) begin
               vnew_in = pwass_pkg::SAT_MAX;
               sat_in  = 1'b1;
            end else begin
               vnew_in = var_sum[31:0];
            end
            state_in = ST_G_WR;
         end

         ST_G_WR: begin
            st_req.wr_var   = vwr_ff;
            st_req.addr     = idx_ff;
            st_req.var_data = vnew_ff;
            prod_in         = 64'(mag_ff) * 64'(s_ff);
            state_in        = ST_G_OUT;
         end

         // clamp and load the output register; hold while it is full
         ST_G_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff;
               rsp_sat_in   = sat_ff;
               if (neg_ff) begin
                  if (prod_hi > 48'h0000_8000_0000) begin
                     rsp_upd_in = 32'h8000_0000;
                     rsp_sat_in = 1'b1;
                  end else begin
                     rsp_upd_in = ~prod_hi[31:0] + 32'd1;
                  end
               end else begin
                  if (prod_hi > 48'h0000_7FFF_FFFF) begin
                     rsp_upd_in = 32'h7FFF_FFFF;
                     rsp_sat_in = 1'b1;
                  end else begin
                     rsp_upd_in = prod_hi[31:0];
                  end
               end
               state_in = ST_IDLE;
            end
         end

         // begin batch: walk the active entries
         ST_B_RD: begin
            st_req.rd_en = 1'b1;
            st_req.addr  = cnt_ff[pwass_pkg::IDX_W-1:0];
            state_in     = ST_B_SQ;
         end

         ST_B_SQ: begin
            v_in       = st_var_q;
            sqrt_start = 1'b1;
            state_in   = ST_B_SQW;
         end

         ST_B_SQW: begin
            if (sqrt_done) begin
               if (denom == '0) begin
                  snew_in  = pwass_pkg::SAT_MAX;
                  state_in = ST_B_DEC;
               end else begin
                  div_start = 1'b1;
                  div_num   = {lr_ff, 16'd0};
                  div_den   = denom;
                  state_in  = ST_B_DIV;
               end
            end
         end

         ST_B_DIV: begin
            if (div_done) begin
               snew_in  = (div_quo[47:32] != '0) ? pwass_pkg::SAT_MAX : div_quo[31:0];
               state_in = ST_B_DEC;
            end
         end

         // write scale and decayed variance, advance
         ST_B_DEC: begin
            st_req.wr_var   = 1'b1;
            st_req.wr_scl   = 1'b1;
            st_req.addr     = cnt_ff[pwass_pkg::IDX_W-1:0];
            st_req.var_data = decay_prod[47:16];
            st_req.scl_data = snew_ff;
            cnt_in          = cnt_ff + 1'b1;
            state_in        = ((cnt_ff + 1'b1) == walk_ff) ? ST_IDLE : ST_B_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         walk_ff      <= '0;
         lr_ff        <= pwass_pkg::LR_RESET;
         beta_ff      <= pwass_pkg::BETA_RESET;
         eps_ff       <= pwass_pkg::EPS_RESET;
         count_ff     <= pwass_pkg::COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         walk_ff      <= walk_in;
         if (csr_write_enable) begin
            case (csr_index)
               pwass_pkg::CSR_LEARNING_RATE: lr_ff    <= csr_write_data;
               pwass_pkg::CSR_DECAY_BETA:    beta_ff  <= csr_write_data[15:0];
               pwass_pkg::CSR_EPSILON:       eps_ff   <= csr_write_data;
               pwass_pkg::CSR_ACTIVE_COUNT:  count_ff <= csr_write_data[pwass_pkg::CNT_W-1:0];
               default: begin
                  lr_ff <= lr_ff;
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      sat_ff     <= sat_in;
      v_ff       <= v_in;
      s_ff       <= s_in;
      vnew_ff    <= vnew_in;
      vwr_ff     <= vwr_in;
      snew_ff    <= snew_in;
      sq_ff      <= sq_in;
      add_ff     <= add_in;
      prod_ff    <= prod_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_upd_ff <= rsp_upd_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_index     = rsp_idx_ff;
   assign rsp_scaled_update = rsp_upd_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

// ----- verif/tb_per_weight_adaptive_step_scaler_core.sv -----
// Testbench for the per-weight adaptive step scaler core: predicts every scaled update
// from its own variance/scale model and checks each rsp_ beat. Depends on pwass_pkg and the core.
module tb_per_weight_adaptive_step_scaler_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 3000000;

   typedef struct {
      logic [pwass_pkg::IDX_W-1:0]  index;
      logic [31:0]                  update;
      logic                         sat;
   } update_type;

   logic              clock, reset;
   logic              req_valid, req_stall, req_opcode;
   logic [pwass_pkg::IDX_W-1:0]  req_weight_index;
   logic signed [31:0] req_gradient_value;
   logic              rsp_valid, rsp_stall, rsp_saturated;
   logic [pwass_pkg::IDX_W-1:0]  rsp_out_index;
   logic signed [31:0] rsp_scaled_update;
   logic              csr_write_enable;
   logic [1:0]        csr_index;
   logic [31:0]       csr_write_data;

   // model state
   logic [31:0] rate_q, eps_q;
   logic [15:0] beta_q;
   logic [8:0]  count_q;
   logic [31:0] variance_q [pwass_pkg::NUM_WEIGHTS];
   logic [31:0] scale_q    [pwass_pkg::NUM_WEIGHTS];
   update_type  pending_updates [$];

   int  errors;
   longint cycles;
   int  walk_tail;
   bit  quiet;
   bit  long_hold_req;
   int  hold_left;

   per_weight_adaptive_step_scaler_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout at %0t", $time);
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] step_for_variance(logic [31:0] v);
      longint unsigned denom, q;
      denom = int_sqrt({16'd0, v, 16'd0}) + {32'd0, eps_q};
      if (denom == 0) return pwass_pkg::SAT_MAX;
      q = {16'd0, rate_q, 16'd0} / denom;
      if (q > 64'hFFFF_FFFF) return pwass_pkg::SAT_MAX;
      return q[31:0];
   endfunction

   // advance the model by one accepted beat
   task automatic predict_beat(logic op, logic [pwass_pkg::IDX_W-1:0] idx, logic [31:0] g);
      longint unsigned mag, v, r, sq, prod;
      int n;
      update_type u;
      logic neg;
      neg = g[31];
      mag = neg ? {32'd0, -g} : {32'd0, g};
      if (op == pwass_pkg::OP_BEGIN_BATCH) begin
         n = (count_q > pwass_pkg::NUM_WEIGHTS) ? pwass_pkg::NUM_WEIGHTS : int'(count_q);
         for (int i = 0; i < n; i++) begin
            scale_q[i] = step_for_variance(variance_q[i]);
            variance_q[i] = 32'(({32'd0, variance_q[i]} * (64'd65536 - beta_q)) >> 16);
         end
         if (n * 80 + 100 > walk_tail) walk_tail = n * 80 + 100;
         return;
      end
      u.index = idx;
      u.sat = 1'b0;
      if (mag != 0) begin
         v = {32'd0, variance_q[idx]};
         if (rate_q == 0) begin
            v = {32'd0, pwass_pkg::SAT_MAX};
            u.sat = 1'b1;
         end else begin
            r = (mag << 16) / rate_q;
            if (r > 64'hFFFF_FFFF) begin
               v = {32'd0, pwass_pkg::SAT_MAX};
               u.sat = 1'b1;
            end else begin
               sq = (r * r) >> 16;
               v += (sq * beta_q) >> 16;
               if (v > 64'hFFFF_FFFF) begin
                  v = {32'd0, pwass_pkg::SAT_MAX};
                  u.sat = 1'b1;
               end
            end
         end
         variance_q[idx] = v[31:0];
      end
      prod = (mag * scale_q[idx]) >> 16;
      if (neg) begin
         if (prod > 64'h8000_0000) begin
            prod = 64'h8000_0000;
            u.sat = 1'b1;
         end
         u.update = -prod[31:0];
      end else begin
         if (prod > 64'h7FFF_FFFF) begin
            prod = 64'h7FFF_FFFF;
            u.sat = 1'b1;
         end
         u.update = prod[31:0];
      end
      pending_updates.push_back(u);
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // send one beat, predict on acceptance, then idle for a random gap that may be zero
   task automatic send_item(logic op, logic [pwass_pkg::IDX_W-1:0] idx, logic [31:0] g);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_weight_index <= idx;
      req_gradient_value <= g;
      do @(posedge clock); while (req_stall);
      predict_beat(op, idx, g);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold until every update is back and any walk has finished
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (walk_tail) @(negedge clock);
      walk_tail = 80;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         pwass_pkg::CSR_LEARNING_RATE: rate_q = data;
         pwass_pkg::CSR_DECAY_BETA:    beta_q = data[15:0];
         pwass_pkg::CSR_EPSILON:       eps_q = data;
         default:                      count_q = data[8:0];
      endcase
   endtask

   task automatic setup(logic [31:0] lr, logic [15:0] beta, logic [31:0] eps, logic [8:0] cnt);
      write_reg(pwass_pkg::CSR_LEARNING_RATE, lr);
      write_reg(pwass_pkg::CSR_DECAY_BETA, {16'd0, beta});
      write_reg(pwass_pkg::CSR_EPSILON, eps);
      write_reg(pwass_pkg::CSR_ACTIVE_COUNT, {23'd0, cnt});
   endtask

   function automatic logic [31:0] rand_gradient();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'd0;
         default: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      endcase
   endfunction

   // response side: random stall, long holds on request
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left = 400;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         hold_left = $urandom_range(15, 50);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 25);
      end
   end

   // check each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      update_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_updates.size() == 0) begin
            $display("%0t unexpected beat: index %0d update %h", $time, rsp_out_index,
                     rsp_scaled_update);
            errors++;
         end else begin
            e = pending_updates.pop_front();
            if (rsp_out_index !== e.index) begin
               $display("%0t out_index exp %0d act %0d", $time, e.index, rsp_out_index);
               errors++;
            end
            if (rsp_scaled_update !== e.update) begin
               $display("%0t scaled_update exp %h act %h", $time, e.update,
                        rsp_scaled_update);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $display("%0t saturated exp %b act %b", $time, e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_item(pwass_pkg::OP_GRADIENT, 8'd0, 32'h0001_0000);
      send_item(pwass_pkg::OP_GRADIENT, 8'd255, 32'h7FFF_FFFF);
      send_item(pwass_pkg::OP_GRADIENT, 8'd7, 32'h8000_0000);
      send_item(pwass_pkg::OP_GRADIENT, 8'd3, 32'hFFFF_FFFF);
      send_item(pwass_pkg::OP_GRADIENT, 8'd128, 32'd0);
      send_item(pwass_pkg::OP_BEGIN_BATCH, 8'd0, 32'd0);
      send_item(pwass_pkg::OP_GRADIENT, 8'd255, 32'hFFFE_0000);
      send_item(pwass_pkg::OP_GRADIENT, 8'd0, 32'h0000_8000);
   endtask

   task automatic test_special_cases();
      // zero rate: zero gradient untouched, nonzero saturates the variance
      setup(32'd0, 16'hFFFF, 32'hFFFF_FFFF, 9'd1);
      send_item(pwass_pkg::OP_GRADIENT, 8'd1, 32'd0);
      send_item(pwass_pkg::OP_GRADIENT, 8'd1, 32'h0000_0001);
      send_item(pwass_pkg::OP_BEGIN_BATCH, 8'hAA, 32'h5555_AAAA);
      send_item(pwass_pkg::OP_GRADIENT, 8'd0, 32'h1234_5678);
      // tiny rate: ratio overflows 32 bits
      write_reg(pwass_pkg::CSR_LEARNING_RATE, 32'd1);
      send_item(pwass_pkg::OP_GRADIENT, 8'd2, 32'h0100_0000);
      // zero epsilon with decayed variance gives a zero denominator
      setup(32'hFFFF_FFFF, 16'hFFFF, 32'd0, 9'd4);
      repeat (3) send_item(pwass_pkg::OP_BEGIN_BATCH, 8'd0, 32'd0);
      send_item(pwass_pkg::OP_GRADIENT, 8'd3, 32'h0000_0002);
      send_item(pwass_pkg::OP_GRADIENT, 8'd3, 32'hFFFF_FFFE);
      send_item(pwass_pkg::OP_GRADIENT, 8'd9, 32'h0000_0010);
      // beta zero, active_count zero walks nothing
      setup(32'h0002_0000, 16'd0, 32'd66, 9'd0);
      send_item(pwass_pkg::OP_BEGIN_BATCH, 8'd0, 32'd0);
      send_item(pwass_pkg::OP_GRADIENT, 8'd3, 32'h0000_0100);
   endtask

   task automatic test_backpressure();
      setup(32'h0001_0000, 16'd6554, 32'd66, 9'd8);
      drain();
      long_hold_req = 1'b1;
      for (int i = 0; i < 12; i++) send_item(pwass_pkg::OP_GRADIENT, i[7:0], rand_gradient());
      drain();
   endtask

   task automatic test_random_traffic();
      logic [31:0] lr, eps;
      logic [15:0] beta;
      logic [8:0]  cnt;
      int span;
      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(0, 3))
            0: lr = 32'hFFFF_FFFF;
            1: lr = $urandom_range(1, 32'h0004_0000);
            2: lr = $urandom;
            default: lr = 32'h0001_0000;
         endcase
         beta = (p == 3) ? 16'hFFFF : 16'($urandom);
         eps = (p == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 500);
         cnt = (p == 4 || p == 9) ? 9'd256 : 9'($urandom_range(1, 16));
         setup(lr, beta, eps, cnt);
         quiet = (p % 4 == 2);
         span = (cnt > 16) ? 16 : int'(cnt);
         for (int k = 0; k < 115; k++) begin
            if ($urandom_range(0, 99) < ((cnt > 16) ? 2 : 10))
               send_item(pwass_pkg::OP_BEGIN_BATCH, 8'($urandom), $urandom);
            else if ($urandom_range(0, 9) < 8)
               send_item(pwass_pkg::OP_GRADIENT, 8'($urandom_range(0, span - 1)),
                         rand_gradient());
            else
               send_item(pwass_pkg::OP_GRADIENT, 8'($urandom), rand_gradient());
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = pwass_pkg::OP_GRADIENT;
      req_weight_index = '0;
      req_gradient_value = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = pwass_pkg::CSR_LEARNING_RATE;
      csr_write_data = '0;
      errors = 0;
      cycles = 0;
      quiet = 1'b0;
      long_hold_req = 1'b0;
      hold_left = 0;
      walk_tail = 80;
      rate_q = pwass_pkg::LR_RESET;
      beta_q = pwass_pkg::BETA_RESET;
      eps_q = pwass_pkg::EPS_RESET;
      count_q = pwass_pkg::COUNT_RESET;
      for (int i = 0; i < pwass_pkg::NUM_WEIGHTS; i++) variance_q[i] = pwass_pkg::VAR_RESET;
      for (int i = 0; i < pwass_pkg::NUM_WEIGHTS; i++)
         scale_q[i] = step_for_variance(pwass_pkg::VAR_RESET);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_backpressure();
      test_random_traffic();
      drain();

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/pwass_pkg.sv
hdl/pwass_store.sv
hdl/pwass_div.sv
hdl/pwass_sqrt.sv
hdl/per_weight_adaptive_step_scaler_core.sv
verif/tb_per_weight_adaptive_step_scaler_core.sv
